// ----- src/tplca_pkg.sv -----
package tplca_pkg;

    // Tree geometry
    localparam int NODE_W    = 10;
    localparam int NODES     = 1 << NODE_W;
    localparam int LEVELS    = 10;
    localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int ANC_DEPTH = NODES * LEVELS;
    localparam int ANC_AW    = $clog2(ANC_DEPTH);

    // Field widths
    localparam int WEIGHT_W  = 32;
    localparam int DEPTH_W   = 10;
    localparam int DIST_W    = 42;
    localparam int COUNT_W   = 11;
    localparam int CMP_W     = ((DEPTH_W > LEVELS) ? DEPTH_W : LEVELS) + 1;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Flat address of one ancestor entry: node row, level column
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                  input logic [LVL_W-1:0] lvl);
        anc_addr = ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl);
    endfunction

endpackage

// ----- src/tree_path_query_lca.sv -----
// Load word: one ancestor-table read per level, then idle.
// Query word: a lifting walk to equal depth, then a joint walk up to the meeting node,
// each step one read of the synchronous ancestor memory.
// One word is worked at a time; busy is high from acceptance until the block is free.
// done is high for one cycle with the result on the ports; the receiver cannot stall.
// Reset (rst_n low, asynchronous) clears control; table contents are undefined until loaded.
module tree_path_query_lca
    import tplca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [NODE_W-1:0]   node_a,
    input  logic [NODE_W-1:0]   node_b,
    input  logic [WEIGHT_W-1:0] edge_weight,
    output logic                done,
    output logic [NODE_W-1:0]   ancestor,
    output logic [DIST_W-1:0]   path_weight,
    output logic [COUNT_W-1:0]  path_nodes
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LD,
        S_Q_SORT,
        S_Q_CMP,
        S_Q_ANC,
        S_Q_DEP,
        S_Q_MEET,
        S_Q_UP,
        S_Q_UPCMP,
        S_Q_PAR,
        S_Q_FIN
    } state_t;

    state_t               state_reg;
    logic [NODE_W-1:0]    a_reg;
    logic [NODE_W-1:0]    b_reg;
    logic [WEIGHT_W-1:0]  w_reg;
    logic [NODE_W-1:0]    cur_reg;
    logic                 fwd_reg;
    logic                 root_reg;
    logic                 first_reg;
    logic [LVL_W-1:0]     lvl_reg;
    logic [NODE_W-1:0]    x_reg;
    logic [NODE_W-1:0]    y_reg;
    logic [DEPTH_W-1:0]   dx_reg;
    logic [DEPTH_W-1:0]   dy_reg;
    logic [NODE_W-1:0]    c_reg;
    logic [DIST_W-1:0]    sum_dist_reg;
    logic [COUNT_W-1:0]   sum_dep_reg;
    logic                 done_reg;
    logic [NODE_W-1:0]    ancestor_reg;
    logic [DIST_W-1:0]    path_weight_reg;
    logic [COUNT_W-1:0]   path_nodes_reg;

    // Memories
    logic [NODE_W-1:0]    anc_mem [ANC_DEPTH];
    logic [DEPTH_W-1:0]   dep_mem [NODES];
    logic [DIST_W-1:0]    dist_mem [NODES];

    logic                 anc_we;
    logic [ANC_AW-1:0]    anc_wa;
    logic [NODE_W-1:0]    anc_wd;
    logic [ANC_AW-1:0]    anc_ra0;
    logic [ANC_AW-1:0]    anc_ra1;
    logic [NODE_W-1:0]    anc_q0;
    logic [NODE_W-1:0]    anc_q1;

    logic                 nd_we;
    logic [DEPTH_W-1:0]   dep_wd;
    logic [DIST_W-1:0]    dist_wd;
    logic [NODE_W-1:0]    nd_ra0;
    logic [NODE_W-1:0]    nd_ra1;
    logic [DEPTH_W-1:0]   dep_q0;
    logic [DEPTH_W-1:0]   dep_q1;
    logic [DIST_W-1:0]    dist_q0;
    logic [DIST_W-1:0]    dist_q1;

    logic                 accept;
    logic [NODE_W-1:0]    ld_val;
    logic [NODE_W-1:0]    up_x;
    logic [NODE_W-1:0]    up_y;
    logic [DEPTH_W:0]     dep_inc;
    logic                 lift_take;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Forward the entry written last cycle when the walk lands on the loaded node
    assign ld_val = fwd_reg ? cur_reg : anc_q0;

    // Jump both nodes where their ancestors differ
    assign up_x = (anc_q0 != anc_q1) ? anc_q0 : x_reg;
    assign up_y = (anc_q0 != anc_q1) ? anc_q1 : y_reg;

    assign dep_inc = {1'b0, dep_q0} + (DEPTH_W + 1)'(1);

    // Lift the deeper node while the gap is at least 2^lvl
    assign lift_take = (CMP_W'(dx_reg) >= (CMP_W'(dy_reg) + (CMP_W'(1) << lvl_reg)));

    // Memory port addressing and write data
    always_comb
    begin
        anc_we  = 1'b0;
        anc_wa  = anc_addr(a_reg, lvl_reg);
        anc_wd  = ld_val;
        anc_ra0 = anc_addr(x_reg, lvl_reg);
        anc_ra1 = anc_addr(y_reg, lvl_reg);
        nd_we   = 1'b0;
        dep_wd  = '0;
        dist_wd = '0;
        nd_ra0  = x_reg;
        nd_ra1  = y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && action == ACT_LOAD)
                begin
                    anc_we  = 1'b1;
                    anc_wa  = anc_addr(node_a, LVL_W'(0));
                    anc_wd  = node_b;
                    anc_ra0 = anc_addr(node_b, LVL_W'(0));
                    nd_ra0  = node_b;
                end
                else
                begin
                    nd_ra0 = node_a;
                    nd_ra1 = node_b;
                end
            end
            S_LD:
            begin
                nd_we = first_reg;
                if (!root_reg)
                begin
                    dep_wd  = dep_inc[DEPTH_W] ? DEPTH_MAX : dep_inc[DEPTH_W-1:0];
                    dist_wd = dist_q0 + DIST_W'(w_reg);
                end
                if (LEVELS > 1)
                begin
                    anc_we  = 1'b1;
                    anc_ra0 = anc_addr(ld_val, lvl_reg);
                end
            end
            S_Q_ANC:
            begin
                nd_ra0 = anc_q0;
            end
            S_Q_UPCMP:
            begin
                anc_ra0 = anc_addr(up_x, LVL_W'(0));
            end
            S_Q_PAR:
            begin
                nd_ra0 = anc_q0;
            end
            default:
            begin
            end
        endcase
    end

    // Ancestor table: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_wa] <= anc_wd;
        end
        anc_q0 <= anc_mem[anc_ra0];
        anc_q1 <= anc_mem[anc_ra1];
    end

    // Depth and root distance tables, written together
    always_ff @(posedge clk)
    begin
        if (nd_we)
        begin
            dep_mem[a_reg]  <= dep_wd;
            dist_mem[a_reg] <= dist_wd;
        end
        dep_q0  <= dep_mem[nd_ra0];
        dep_q1  <= dep_mem[nd_ra1];
        dist_q0 <= dist_mem[nd_ra0];
        dist_q1 <= dist_mem[nd_ra1];
    end

    // Sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            a_reg           <= '0;
            b_reg           <= '0;
            w_reg           <= '0;
            cur_reg         <= '0;
            fwd_reg         <= 1'b0;
            root_reg        <= 1'b0;
            first_reg       <= 1'b0;
            lvl_reg         <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            dx_reg          <= '0;
            dy_reg          <= '0;
            c_reg           <= '0;
            sum_dist_reg    <= '0;
            sum_dep_reg     <= '0;
            done_reg        <= 1'b0;
            ancestor_reg    <= '0;
            path_weight_reg <= '0;
            path_nodes_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        a_reg <= node_a;
                        b_reg <= node_b;
                        w_reg <= edge_weight;
                        if (action == ACT_LOAD)
                        begin
                            cur_reg   <= node_b;
                            fwd_reg   <= (node_a == node_b);
                            root_reg  <= (node_a == node_b);
                            first_reg <= 1'b1;
                            lvl_reg   <= LVL_W'(1);
                            state_reg <= S_LD;
                        end
                        else
                        begin
                            state_reg <= S_Q_SORT;
                        end
                    end
                end
                S_LD:
                begin
                    // advance one ancestor level per cycle
                    first_reg <= 1'b0;
                    if (LEVELS > 1)
                    begin
                        cur_reg <= ld_val;
                        fwd_reg <= (ld_val == a_reg);
                    end
                    if (LEVELS == 1 || lvl_reg == LVL_W'(LEVELS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                S_Q_SORT:
                begin
                    // put the deeper node in x
                    if (dep_q0 < dep_q1)
                    begin
                        x_reg  <= b_reg;
                        dx_reg <= dep_q1;
                        y_reg  <= a_reg;
                        dy_reg <= dep_q0;
                    end
                    else
                    begin
                        x_reg  <= a_reg;
                        dx_reg <= dep_q0;
                        y_reg  <= b_reg;
                        dy_reg <= dep_q1;
                    end
                    sum_dist_reg <= dist_q0 + dist_q1;
                    sum_dep_reg  <= COUNT_W'(dep_q0) + COUNT_W'(dep_q1);
                    lvl_reg      <= LVL_W'(LEVELS - 1);
                    state_reg    <= S_Q_CMP;
                end
                S_Q_CMP:
                begin
                    if (lift_take)
                    begin
                        state_reg <= S_Q_ANC;
                    end
                    else if (lvl_reg == '0)
                    begin
                        state_reg <= S_Q_MEET;
                    end
                    else
                    begin
                        lvl_reg <= lvl_reg - LVL_W'(1);
                    end
                end
                S_Q_ANC:
                begin
                    x_reg     <= anc_q0;
                    state_reg <= S_Q_DEP;
                end
                S_Q_DEP:
                begin
                    dx_reg <= dep_q0;
                    if (lvl_reg == '0)
                    begin
                        state_reg <= S_Q_MEET;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg - LVL_W'(1);
                        state_reg <= S_Q_CMP;
                    end
                end
                S_Q_MEET:
                begin
                    if (x_reg == y_reg)
                    begin
                        c_reg     <= x_reg;
                        state_reg <= S_Q_FIN;
                    end
                    else
                    begin
                        lvl_reg   <= LVL_W'(LEVELS - 1);
                        state_reg <= S_Q_UP;
                    end
                end
                S_Q_UP:
                begin
                    state_reg <= S_Q_UPCMP;
                end
                S_Q_UPCMP:
                begin
                    x_reg <= up_x;
                    y_reg <= up_y;
                    if (lvl_reg == '0)
                    begin
                        state_reg <= S_Q_PAR;
                    end
                    else
                    begin
                        lvl_reg   <= lvl_reg - LVL_W'(1);
                        state_reg <= S_Q_UP;
                    end
                end
                S_Q_PAR:
                begin
                    c_reg     <= anc_q0;
                    state_reg <= S_Q_FIN;
                end
                S_Q_FIN:
                begin
                    // drop the doubled ancestor share from both sums
                    ancestor_reg    <= c_reg;
                    path_weight_reg <= sum_dist_reg - (dist_q0 << 1);
                    path_nodes_reg  <= sum_dep_reg - (COUNT_W'(dep_q0) << 1)
                                       + COUNT_W'(1);
                    done_reg        <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign ancestor    = ancestor_reg;
    assign path_weight = path_weight_reg;
    assign path_nodes  = path_nodes_reg;

endmodule

// ----- sim/tree_path_query_lca_check.sv -----
`timescale 1ns / 1ps

module tree_path_query_lca_check
    import tplca_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                action,
    input  logic [NODE_W-1:0]   node_a,
    input  logic [NODE_W-1:0]   node_b,
    input  logic [WEIGHT_W-1:0] edge_weight,
    input  logic                done,
    input  logic [NODE_W-1:0]   ancestor,
    input  logic [DIST_W-1:0]   path_weight,
    input  logic [COUNT_W-1:0]  path_nodes,
    output int                  mismatches,
    output int                  queries_open
);

    typedef struct packed {
        logic [NODE_W-1:0]  meet;
        logic [DIST_W-1:0]  weight;
        logic [COUNT_W-1:0] count;
    } path_answer_t;

    // Shadow copy of the tree tables
    logic [NODE_W-1:0]  lift_row [NODES][LEVELS];
    logic [DEPTH_W-1:0] depth_of [NODES];
    logic [DIST_W-1:0]  dist_of  [NODES];

    path_answer_t answers_due [$];
    path_answer_t want;
    int           answers_seen;

    // Lift the deeper node to the same depth, then lift both until they meet
    function automatic logic [NODE_W-1:0] meeting_node(input logic [NODE_W-1:0] x_in,
                                                       input logic [NODE_W-1:0] y_in);
        logic [NODE_W-1:0] x;
        logic [NODE_W-1:0] y;
        logic [NODE_W-1:0] t;
        int                lv;
        x = x_in;
        y = y_in;
        if (depth_of[x] < depth_of[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        for (lv = LEVELS - 1; lv >= 0; lv--)
        begin
            if (32'(depth_of[x]) >= 32'(depth_of[y]) + (32'd1 << lv))
                x = lift_row[x][lv];
        end
        if (x == y)
            return x;
        for (lv = LEVELS - 1; lv >= 0; lv--)
        begin
            if (lift_row[x][lv] != lift_row[y][lv])
            begin
                x = lift_row[x][lv];
                y = lift_row[y][lv];
            end
        end
        return lift_row[x][0];
    endfunction

    // Meeting node, path weight and node count for one query word
    function automatic path_answer_t solve_path(input logic [NODE_W-1:0] a,
                                                input logic [NODE_W-1:0] b);
        path_answer_t      ans;
        logic [NODE_W-1:0] c;
        logic [31:0]       hops;
        c          = meeting_node(a, b);
        ans.meet   = c;
        ans.weight = dist_of[a] + dist_of[b] - (dist_of[c] << 1);
        hops       = 32'(depth_of[a]) + 32'(depth_of[b]) - (32'(depth_of[c]) << 1) + 32'd1;
        ans.count  = hops[COUNT_W-1:0];
        return ans;
    endfunction

    // Write depth, distance and ancestor row of a loaded node
    function automatic void store_node(input logic [NODE_W-1:0]   a,
                                       input logic [NODE_W-1:0]   b,
                                       input logic [WEIGHT_W-1:0] w);
        logic [31:0] deeper;
        int          lv;
        if (a == b)
        begin
            depth_of[a] = '0;
            dist_of[a]  = '0;
        end
        else
        begin
            deeper      = 32'(depth_of[b]) + 32'd1;
            depth_of[a] = (deeper > 32'(DEPTH_MAX)) ? DEPTH_MAX : deeper[DEPTH_W-1:0];
            dist_of[a]  = dist_of[b] + DIST_W'(w);
        end
        lift_row[a][0] = b;
        for (lv = 1; lv < LEVELS; lv++)
            lift_row[a][lv] = lift_row[lift_row[a][lv-1]][lv-1];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mismatches   = 0;
            queries_open = 0;
            answers_seen = 0;
        end
        else
        begin
            // Compare the result word against the oldest prediction
            if (done)
            begin
                answers_seen++;
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with no query waiting:", answers_seen,
                                 " ancestor %0d weight %0d", ancestor, path_weight,
                                 " nodes %0d", path_nodes);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (ancestor !== want.meet || path_weight !== want.weight ||
                        path_nodes !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d mismatch (expected/actual):",
                                     answers_seen,
                                     " ancestor %0d/%0d", want.meet, ancestor,
                                     " weight %0d/%0d", want.weight, path_weight,
                                     " nodes %0d/%0d", want.count, path_nodes);
                    end
                end
            end

            // Apply an accepted word to the shadow tables or predict its answer
            if (start && !busy)
            begin
                if (action == ACT_QUERY)
                    answers_due = {answers_due, solve_path(node_a, node_b)};
                else
                    store_node(node_a, node_b, edge_weight);
            end

            queries_open = answers_due.size();
        end
    end

endmodule

// ----- sim/tree_path_query_lca_tb.sv -----
`timescale 1ns / 1ps

module tree_path_query_lca_tb;
    import tplca_pkg::*;

    localparam int RUN_LIMIT   = 1_000_000;
    localparam int MIXED_FIRST = 300;
    localparam int CHAIN_LOADS = 1040;
    localparam int MIXED_LAST  = 200;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic                action      = ACT_LOAD;
    logic [NODE_W-1:0]   node_a      = '0;
    logic [NODE_W-1:0]   node_b      = '0;
    logic [WEIGHT_W-1:0] edge_weight = '0;
    logic                busy;
    logic                done;
    logic [NODE_W-1:0]   ancestor;
    logic [DIST_W-1:0]   path_weight;
    logic [COUNT_W-1:0]  path_nodes;

    int                mismatches;
    int                queries_open;
    int                cycle_count = 0;
    int                gap_pct     = 0;
    bit                loaded [NODES];
    int                loaded_list [$];
    logic [NODE_W-1:0] tip = '0;

    always #5 clk = ~clk;

    tree_path_query_lca dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .node_a      (node_a),
        .node_b      (node_b),
        .edge_weight (edge_weight),
        .done        (done),
        .ancestor    (ancestor),
        .path_weight (path_weight),
        .path_nodes  (path_nodes)
    );

    tree_path_query_lca_check lca_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .node_a       (node_a),
        .node_b       (node_b),
        .edge_weight  (edge_weight),
        .done         (done),
        .ancestor     (ancestor),
        .path_weight  (path_weight),
        .path_nodes   (path_nodes),
        .mismatches   (mismatches),
        .queries_open (queries_open)
    );

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tree_path_query_lca_tb: done, errors");
            $finish;
        end
    end

    // Present one word at the falling edge and hold it until accepted
    task automatic send_word(input logic                act,
                             input logic [NODE_W-1:0]   a,
                             input logic [NODE_W-1:0]   b,
                             input logic [WEIGHT_W-1:0] w);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        action      <= act;
        node_a      <= a;
        node_b      <= b;
        edge_weight <= w;
        // busy moves only at the rising edge, so its value here holds through it
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic load_node(input logic [NODE_W-1:0]   n,
                             input logic [NODE_W-1:0]   parent,
                             input logic [WEIGHT_W-1:0] w);
        send_word(ACT_LOAD, n, parent, w);
        if (!loaded[n])
        begin
            loaded[n] = 1'b1;
            loaded_list = {loaded_list, int'(n)};
        end
        tip = n;
    endtask

    task automatic ask_path(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
        send_word(ACT_QUERY, a, b, $urandom);
    endtask

    // Hold the sender until every query word has answered
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (queries_open != 0)
            @(negedge clk);
    endtask

    function automatic logic [NODE_W-1:0] any_loaded();
        return NODE_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
    endfunction

    // Favor the extremes of the weight
    function automatic logic [WEIGHT_W-1:0] draw_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return '1;
        if (r == 3)
            return '0;
        return $urandom;
    endfunction

    // Mix of fresh nodes, reloads, new roots and queries over loaded nodes
    task automatic mixed_run(input int count);
        logic [NODE_W-1:0] n;
        logic [NODE_W-1:0] parent;
        logic [NODE_W-1:0] other;
        logic [NODE_W-1:0] probe;
        bit                found;
        int                k;
        int                t;
        int                r;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 50)
            begin
                n     = any_loaded();
                found = 1'b0;
                if ($urandom_range(0, 3) != 0)
                begin
                    for (t = 0; t < 8 && !found; t++)
                    begin
                        probe = NODE_W'($urandom_range(0, NODES - 1));
                        if (!loaded[probe])
                        begin
                            n     = probe;
                            found = 1'b1;
                        end
                    end
                end
                r = $urandom_range(0, 99);
                if (r < 4)
                    parent = n;
                else if (r < 55)
                    parent = tip;
                else
                    parent = any_loaded();
                load_node(n, parent, draw_weight());
            end
            else
            begin
                n = any_loaded();
                r = $urandom_range(0, 99);
                if (r < 15)
                    other = n;
                else if (r < 35)
                    other = tip;
                else
                    other = any_loaded();
                ask_path(n, other);
            end
        end
    endtask

    // Hang each node under the previous one so depth climbs to saturation
    task automatic chain_run(input int loads);
        logic [NODE_W-1:0]   n;
        logic [WEIGHT_W-1:0] w;
        int                  k;
        for (k = 0; k < loads; k++)
        begin
            n = tip + NODE_W'($urandom_range(1, NODES - 1));
            w = ($urandom_range(0, 9) < 6) ? ($urandom | 32'hF000_0000) : $urandom;
            load_node(n, tip, w);
            if (k % 5 == 4)
                ask_path(tip, any_loaded());
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        gap_pct = 17;

        // Small tree with extreme indexes and weights
        load_node(10'd0, 10'd0, 32'hFFFF_FFFF);
        load_node(10'd1023, 10'd0, 32'hFFFF_FFFF);
        load_node(10'd682, 10'd1023, 32'h0000_0000);
        load_node(10'd341, 10'd1023, 32'h5555_5555);
        ask_path(10'd0, 10'd0);
        ask_path(10'd1023, 10'd0);
        ask_path(10'd682, 10'd341);
        ask_path(10'd341, 10'd682);
        ask_path(10'd682, 10'd682);
        ask_path(10'd0, 10'd682);
        // Second tree, then queries across the two
        load_node(10'd512, 10'd512, $urandom);
        load_node(10'd1, 10'd512, 32'd1);
        ask_path(10'd1, 10'd682);
        ask_path(10'd512, 10'd0);
        // Reload under another tree: children keep their old entries
        load_node(10'd1023, 10'd512, 32'd7);
        ask_path(10'd682, 10'd1023);
        ask_path(10'd341, 10'd1);
        // Reload a root under its own grandchild, then make that grandchild a root
        load_node(10'd0, 10'd682, 32'hFFFF_FFFF);
        ask_path(10'd0, 10'd341);
        load_node(10'd682, 10'd682, 32'hFFFF_FFFF);
        ask_path(10'd682, 10'd0);

        mixed_run(MIXED_FIRST);
        drain();

        gap_pct = 73;
        chain_run(CHAIN_LOADS);
        drain();

        gap_pct = 0;
        mixed_run(MIXED_LAST);
        drain();

        repeat (60) @(posedge clk);
        if (mismatches == 0 && queries_open == 0)
            $display("tree_path_query_lca_tb: done, clean");
        else
            $display("tree_path_query_lca_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
src/tplca_pkg.sv
src/tree_path_query_lca.sv
sim/tree_path_query_lca_check.sv
sim/tree_path_query_lca_tb.sv
